/* rtl/core/ldf_pkg.sv */
// Shared types and codes for the length-prefixed frame deframer.
package ldf_pkg;

	localparam int HDR_WORD_CNT = 4;
	localparam int HDR_CNT_W    = 4;
	localparam int CFG_INDEX_W  = 1;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_WORD = 3'd1;
	localparam logic [2:0] KIND_BODY = 3'd2;
	localparam logic [2:0] KIND_GOOD = 3'd3;
	localparam logic [2:0] KIND_ERR  = 3'd4;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_START = 2'd1;
	localparam logic [1:0] ERR_TRUNC = 2'd2;
	localparam logic [1:0] ERR_TERM  = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE   = 1'd1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  out_kind;
		logic [31:0] out_value;
		logic [1:0]  out_word_index;
		logic [1:0]  out_error;
	} out_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

/* rtl/core/ldf_front.sv */
// Front end: accepts buffer bytes, tracks frame phase and builds one result per byte.
module ldf_front
	import ldf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	input  queue_stat_t            q_stat,
	output logic                   push,
	output out_item_t              push_data
);

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_BODY   = 3'd2;
	localparam logic [2:0] PH_TERM   = 3'd3;
	localparam logic [2:0] PH_DRAIN  = 3'd4;

	logic [7:0]           start_byte_q;
	logic [7:0]           end_byte_q;
	logic [2:0]           phase_q;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [31:0]          word_q;
	logic [31:0]          body_rem_q;

	logic [2:0]           phase_d;
	logic [HDR_CNT_W-1:0] hdr_cnt_d;
	logic [31:0]          word_d;
	logic [31:0]          body_rem_d;
	logic [31:0]          assembled;
	out_item_t            res;
	logic                 acc;

	assign in_stall  = q_stat.full;
	assign acc       = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign push      = acc;
	assign push_data = res;

	assign assembled = word_q | (32'(in_data.in_byte) << {hdr_cnt_q[1:0], 3'b000});

	always_comb begin
		res        = '0;
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		word_d     = word_q;
		body_rem_d = body_rem_q;
		unique case (phase_q)
			PH_START: begin
				if (in_data.in_byte != start_byte_q) begin
					res.out_kind  = KIND_ERR;
					res.out_error = ERR_START;
					phase_d       = PH_DRAIN;
				end else begin
					hdr_cnt_d  = '0;
					word_d     = '0;
					body_rem_d = '0;
					phase_d    = PH_HEADER;
				end
			end
			PH_HEADER: begin
				if (hdr_cnt_q[1:0] == 2'd3) begin
					res.out_kind       = KIND_WORD;
					res.out_value      = assembled;
					res.out_word_index = hdr_cnt_q[3:2];
					if (hdr_cnt_q[3:2] == 2'd1) begin
						body_rem_d = assembled;
					end
					word_d = '0;
					if (hdr_cnt_q == HDR_CNT_W'(4 * HDR_WORD_CNT - 1)) begin
						phase_d = (body_rem_q != '0) ? PH_BODY : PH_TERM;
					end
				end else begin
					word_d = assembled;
				end
				hdr_cnt_d = hdr_cnt_q + 1'b1;
			end
			PH_BODY: begin
				res.out_kind  = KIND_BODY;
				res.out_value = {24'd0, in_data.in_byte};
				body_rem_d    = body_rem_q - 1'b1;
				if (body_rem_q == 32'd1) begin
					phase_d = PH_TERM;
				end
			end
			PH_TERM: begin
				if (in_data.in_byte == end_byte_q) begin
					res.out_kind = KIND_GOOD;
				end else begin
					res.out_kind  = KIND_ERR;
					res.out_error = ERR_TERM;
				end
				phase_d = PH_DRAIN;
			end
			default: begin
				phase_d = PH_DRAIN;
			end
		endcase
		if (in_data.in_last) begin
			if (phase_q == PH_HEADER || phase_q == PH_BODY ||
			    (phase_q == PH_START && res.out_kind == KIND_NONE)) begin
				res           = '0;
				res.out_kind  = KIND_ERR;
				res.out_error = ERR_TRUNC;
			end
			phase_d = PH_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= 8'd1;
			end_byte_q   <= 8'd4;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_START_BYTE) begin
				start_byte_q <= cfg_data;
			end else if (cfg_index == CFG_END_BYTE) begin
				end_byte_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			hdr_cnt_q  <= '0;
			word_q     <= '0;
			body_rem_q <= '0;
		end else if (acc) begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			word_q     <= word_d;
			body_rem_q <= body_rem_d;
		end
	end

	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_data.in_last |=> phase_q == PH_START)
		else $error("last byte did not re-arm the deframer");

	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> body_rem_q != '0)
		else $error("body phase with no bytes remaining");

	a_header_exit: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !in_data.in_last && phase_q == PH_HEADER &&
		hdr_cnt_q == HDR_CNT_W'(4 * HDR_WORD_CNT - 1)
		|=> phase_q == PH_BODY || phase_q == PH_TERM)
		else $error("header end did not move to body or terminator");

endmodule

/* rtl/core/ldf_queue.sv */
// Short result queue that decouples the front end from the output stage.
module ldf_queue
	import ldf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  out_item_t   push_data,
	input  logic        pop,
	output out_item_t   pop_data,
	output queue_stat_t q_stat
);

	out_item_t              mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_data     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("result queue written while full");

endmodule

/* rtl/core/ldf_back.sv */
// Back end: output register that hands queued results to the downstream side.
module ldf_back
	import ldf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  queue_stat_t q_stat,
	input  out_item_t   pop_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	logic      out_valid_q;
	out_item_t out_data_q;

	assign pop       = !q_stat.empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= pop_data;
		end
	end

endmodule

/* rtl/core/length_prefixed_frame_deframer_core.sv */
// Top level of the length-prefixed frame deframer.
// Every accepted byte yields exactly one result, one byte per cycle sustained while the output is not stalled.
// A result is written into the result queue and from there into the output register.
// A four-entry result queue between the front end and output register absorbs stalls.
// Reset clears the phase to awaiting start, start byte to 1 and end byte to 4.
module length_prefixed_frame_deframer_core
	import ldf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data
);

	queue_stat_t q_stat;
	logic        push;
	out_item_t   push_data;
	logic        pop;
	out_item_t   pop_data;

	ldf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	ldf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	ldf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
